[rtl/core/tccw_pkg.sv]
// Constants and request codes for the text console cell writer.
`default_nettype none

package tccw_pkg;

	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_BS    = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam logic [7:0] BLANK_CODE   = 8'h08;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] ERROR_CHAR   = 8'h45;
	localparam logic [7:0] SPACE_CHAR   = 8'h20;
	localparam logic [7:0] NULL_CHAR    = 8'h00;

	localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
	localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

	localparam logic REG_DEFAULT_ATTR = 1'b0;
	localparam logic REG_ERROR_ATTR   = 1'b1;

endpackage

`default_nettype wire

[rtl/core/text_console_cell_writer.sv]
// Text console: cell store, cursor, request sequencer and register port.
//
// Requests come in on in_valid/in_ready and each one gives one result on
// out_valid/out_ready. in_ready is high whenever the sequencer is idle; a
// result waiting in the output register does not block the next request,
// which runs and then holds in a finish state until the output is taken.
// The cells live in one single-port-write memory of COLS*ROWS entries with
// a registered read. A put, backspace or off-screen put is accepted and
// then finished in the execute state; an on-screen read also waits in a
// read-data state for the registered data. A put that passes the last cell
// scrolls: each cell of the upper ROWS-1 rows is copied from the row below,
// then the last row is filled. Clear writes every cell. Reset clears the
// cursor and the control state and sets the registers to their reset
// values; the cell store is undefined until written or cleared. Registers
// sit on an APB port at byte addresses 0 (default_attr) and 4 (error_attr),
// pready always high.
// A stalled receiver only holds the finished result; nothing is dropped.
`default_nettype none

module text_console_cell_writer
	import tccw_pkg::*;
#(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  char_code,
	input  wire logic [7:0]  attr,
	input  wire logic        use_cursor,
	input  wire logic [6:0]  col,
	input  wire logic [4:0]  row,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [6:0]       cursor_col,
	output logic [4:0]       cursor_row,
	output logic             position_error,
	output logic             scrolled,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_attr,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CELLS = COLS * ROWS;
	localparam int AW    = $clog2(CELLS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_RDATA  = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_FILL   = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	logic [2:0]    state_q;
	logic [7:0]    default_attr_q;
	logic [7:0]    error_attr_q;

	logic [1:0]    req_q;
	logic [7:0]    char_q;
	logic [7:0]    attr_q;
	logic          off_q;
	logic [6:0]    tcol_q;
	logic [4:0]    trow_q;

	logic [6:0]    col_q;
	logic [4:0]    row_q;

	logic [AW-1:0] cnt_q;
	logic [AW-1:0] sdst_s1;
	logic          svld_s1;
	logic [15:0]   rdata_q;
	logic [15:0]   mem [CELLS];

	logic          res_perr_q;
	logic          res_scr_q;
	logic [7:0]    res_char_q;
	logic [7:0]    res_attr_q;

	logic          out_valid_q;
	logic [6:0]    out_col_q;
	logic [4:0]    out_row_q;
	logic          out_perr_q;
	logic          out_scr_q;
	logic [7:0]    out_char_q;
	logic [7:0]    out_attr_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic          complete;
	logic          go_scroll;
	logic          go_fill;
	logic          go_rdata;
	logic [6:0]    c_col;
	logic [4:0]    c_row;
	logic          c_perr;
	logic          c_scr;
	logic [7:0]    c_char;
	logic [7:0]    c_attr;
	logic [6:0]    acol;
	logic [4:0]    arow;
	logic [AW-1:0] addr_lin;
	logic [7:0]    eff_attr;
	logic          last_col;
	logic          last_row;
	logic          in_off;
	logic          load_out;
	logic          cfg_wr;

	assign in_ready = (state_q == ST_IDLE);
	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign prdata   = {24'd0, (paddr[2] == REG_ERROR_ATTR) ? error_attr_q : default_attr_q};

	assign in_off   = !use_cursor && ((col >= 7'(COLS)) || (row >= 5'(ROWS)));
	assign eff_attr = (attr_q != 8'd0) ? attr_q : default_attr_q;
	assign last_col = (tcol_q == 7'(COLS - 1));
	assign last_row = (trow_q == 5'(ROWS - 1));
	assign addr_lin = AW'(arow) * AW'(COLS) + AW'(acol);
	assign load_out = complete && (!out_valid_q || out_ready);

	always_comb begin
		we        = 1'b0;
		waddr     = cnt_q;
		wdata     = 16'd0;
		re        = 1'b0;
		raddr     = addr_lin;
		complete  = 1'b0;
		go_scroll = 1'b0;
		go_fill   = 1'b0;
		go_rdata  = 1'b0;
		acol      = tcol_q;
		arow      = trow_q;
		c_col     = col_q;
		c_row     = row_q;
		c_perr    = res_perr_q;
		c_scr     = res_scr_q;
		c_char    = res_char_q;
		c_attr    = res_attr_q;
		case (state_q)
			ST_EXEC: begin
				c_perr = 1'b0;
				c_scr  = 1'b0;
				c_char = 8'd0;
				c_attr = 8'd0;
				case (req_q)
					REQ_PUT: begin
						if (off_q) begin
							we       = 1'b1;
							waddr    = AW'(CELLS - 1);
							wdata    = {ERROR_CHAR, error_attr_q};
							c_perr   = 1'b1;
							complete = 1'b1;
						end else begin
							waddr = addr_lin;
							if (char_q == NEWLINE_CODE) begin
								c_col = 7'd0;
								c_row = trow_q + 5'd1;
								c_scr = last_row;
							end else if (char_q == BLANK_CODE) begin
								we    = 1'b1;
								wdata = {SPACE_CHAR, eff_attr};
								c_col = tcol_q;
								c_row = trow_q;
							end else begin
								we    = 1'b1;
								wdata = {char_q, eff_attr};
								if (last_col) begin
									c_col = 7'd0;
									c_row = trow_q + 5'd1;
									c_scr = last_row;
								end else begin
									c_col = tcol_q + 7'd1;
									c_row = trow_q;
								end
							end
							if (c_scr) begin
								c_col     = 7'd0;
								c_row     = 5'(ROWS - 1);
								go_scroll = 1'b1;
							end else begin
								complete = 1'b1;
							end
						end
					end
					REQ_BS: begin
						if (col_q != 7'd0) begin
							acol = col_q - 7'd1;
							arow = row_q;
						end else if (row_q != 5'd0) begin
							acol = 7'(COLS - 1);
							arow = row_q - 5'd1;
						end else begin
							acol = 7'd0;
							arow = 5'd0;
						end
						we       = 1'b1;
						waddr    = addr_lin;
						wdata    = {SPACE_CHAR, default_attr_q};
						c_col    = acol;
						c_row    = arow;
						complete = 1'b1;
					end
					REQ_CLEAR: begin
						c_col   = 7'd0;
						c_row   = 5'd0;
						go_fill = 1'b1;
					end
					default: begin
						if (off_q) begin
							c_perr   = 1'b1;
							complete = 1'b1;
						end else begin
							re       = 1'b1;
							go_rdata = 1'b1;
						end
					end
				endcase
			end
			ST_RDATA: begin
				c_char   = rdata_q[15:8];
				c_attr   = rdata_q[7:0];
				complete = 1'b1;
			end
			ST_SCROLL: begin
				re    = (cnt_q < AW'(CELLS - COLS));
				raddr = cnt_q + AW'(COLS);
				we    = svld_s1;
				waddr = sdst_s1;
				wdata = rdata_q;
			end
			ST_FILL: begin
				we       = 1'b1;
				waddr    = cnt_q;
				wdata    = {(req_q == REQ_CLEAR) ? SPACE_CHAR : NULL_CHAR, default_attr_q};
				complete = (cnt_q == AW'(CELLS - 1));
			end
			ST_FIN: begin
				complete = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		sdst_s1 <= cnt_q;
		if (in_valid && in_ready) begin
			req_q  <= req_type;
			char_q <= char_code;
			attr_q <= attr;
			off_q  <= in_off;
			tcol_q <= use_cursor ? col_q : col;
			trow_q <= use_cursor ? row_q : row;
		end
		if (state_q == ST_EXEC || complete) begin
			res_perr_q <= c_perr;
			res_scr_q  <= c_scr;
			res_char_q <= c_char;
			res_attr_q <= c_attr;
		end
		if (load_out) begin
			out_col_q  <= c_col;
			out_row_q  <= c_row;
			out_perr_q <= c_perr;
			out_scr_q  <= c_scr;
			out_char_q <= c_char;
			out_attr_q <= c_attr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= DEFAULT_ATTR_RST;
			error_attr_q   <= ERROR_ATTR_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ERROR_ATTR) begin
				error_attr_q <= pwdata[7:0];
			end else begin
				default_attr_q <= pwdata[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= 7'd0;
			row_q       <= 5'd0;
			cnt_q       <= '0;
			svld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			svld_s1 <= re && (state_q == ST_SCROLL);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_EXEC) begin
				col_q <= c_col;
				row_q <= c_row;
			end
			if (complete) begin
				state_q <= load_out ? ST_IDLE : ST_FIN;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (in_valid) begin
							state_q <= ST_EXEC;
						end
					end
					ST_EXEC: begin
						cnt_q <= '0;
						if (go_scroll) begin
							state_q <= ST_SCROLL;
						end else if (go_fill) begin
							state_q <= ST_FILL;
						end else if (go_rdata) begin
							state_q <= ST_RDATA;
						end else begin
							state_q <= ST_IDLE;
						end
					end
					ST_SCROLL: begin
						if (cnt_q == AW'(CELLS - COLS)) begin
							state_q <= ST_FILL;
						end else begin
							cnt_q <= cnt_q + AW'(1);
						end
					end
					ST_FILL: begin
						cnt_q <= cnt_q + AW'(1);
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign cursor_col     = out_col_q;
	assign cursor_row     = out_row_q;
	assign position_error = out_perr_q;
	assign scrolled       = out_scr_q;
	assign cell_char      = out_char_q;
	assign cell_attr      = out_attr_q;

endmodule

`default_nettype wire
